/* rtl/core/line_follow_pid_differential_drive_defines.svh */
// Assertion helpers shared by the controller RTL.
`ifndef LINE_FOLLOW_PID_DIFFERENTIAL_DRIVE_DEFINES_SVH
`define LINE_FOLLOW_PID_DIFFERENTIAL_DRIVE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define LFPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lfpd_pkg.sv */
package lfpd_pkg;

    // Field and register widths
    localparam int POS_W      = 13;
    localparam int ERR_W      = 14;
    localparam int SETP_W     = 13;
    localparam int GAIN_W     = 20;
    localparam int PERIOD_W   = 16;
    localparam int SPEED_W    = 8;
    localparam int LIMIT_W    = 13;
    localparam int CMD_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Internal arithmetic widths
    localparam int INTEG_W  = 31;
    localparam int QUOT_W   = 13;
    localparam int FRAC_W   = 16;
    localparam int MUL_A_W  = 31;
    localparam int MUL_B_W  = 20;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = 37;

    // Register reset values
    localparam logic [SETP_W-1:0]   SETPOINT_RST    = 13'd3500;
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 20'd4588;
    localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST  = 20'd52;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = 20'd32768;
    localparam logic [PERIOD_W-1:0] LOOP_PERIOD_RST = 16'd250;
    localparam logic [SPEED_W-1:0]  BASE_SPEED_RST  = 8'd50;
    localparam logic [SPEED_W-1:0]  MAX_SPEED_RST   = 8'd75;
    localparam logic [LIMIT_W-1:0]  INTEG_LIMIT_RST = 13'd7000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT    = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_DERIV_GAIN  = 3'd3,
        REG_LOOP_PERIOD = 3'd4,
        REG_BASE_SPEED  = 3'd5,
        REG_MAX_SPEED   = 3'd6,
        REG_INTEG_LIMIT = 3'd7
    } t_reg_idx;

    // Status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

/* rtl/core/lfpd_in_if.sv */
interface lfpd_in_if;
    import lfpd_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

/* rtl/core/lfpd_out_if.sv */
interface lfpd_out_if;
    import lfpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic [CMD_W-1:0]   command;

    modport source (output valid, output left_speed, output right_speed, output command,
                    input ready);
    modport sink   (input valid, input left_speed, input right_speed, input command,
                    output ready);
endinterface

/* rtl/core/lfpd_mul.sv */
`include "line_follow_pid_differential_drive_defines.svh"

module lfpd_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lfpd_pkg::MUL_A_W-1:0] i_a,
    input  logic [lfpd_pkg::MUL_B_W-1:0] i_b,
    output lfpd_pkg::t_unit_sts          o_sts,
    output logic [lfpd_pkg::MUL_P_W-1:0] o_prod
);
    import lfpd_pkg::*;

    localparam int               CNT_W = $clog2(MUL_B_W);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(MUL_B_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_A_W:0]   w_sum;
    logic [MUL_P_W-1:0] n_acc;

    // Add the multiplicand when the current multiplier bit is set, then shift right
    assign w_sum = {1'b0, r_acc[MUL_P_W-1:MUL_B_W]} + (r_acc[0] ? {1'b0, r_a} : '0);
    assign n_acc = {w_sum, r_acc[MUL_B_W-1:1]};

    // Sequence one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then advance the partial product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= {{MUL_A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

    `LFPD_ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "multiplier restarted mid-run")
    `LFPD_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "multiplier done held two cycles")
    `LFPD_ASSERT_IMPL(a_fell_done, i_clk, i_rst_n, $fell(r_busy), r_done, "multiplier stopped without done")

endmodule

/* rtl/core/lfpd_div.sv */
module lfpd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lfpd_pkg::QUOT_W-1:0]   i_dividend,
    input  logic [lfpd_pkg::PERIOD_W-1:0] i_divisor,
    output lfpd_pkg::t_unit_sts           o_sts,
    output logic [lfpd_pkg::QUOT_W-1:0]   o_quot
);
    import lfpd_pkg::*;

    localparam int               CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(QUOT_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PERIOD_W-1:0] r_dvs;
    logic [PERIOD_W-1:0] r_rem;
    logic [QUOT_W-1:0]   r_q;
    logic [PERIOD_W:0]   w_trial;
    logic [PERIOD_W:0]   w_diff;
    logic                w_ge;
    logic [PERIOD_W-1:0] n_rem;
    logic [QUOT_W-1:0]   n_q;

    // Bring down one dividend bit and try the subtract
    assign w_trial = {r_rem, r_q[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign n_rem   = w_ge ? w_diff[PERIOD_W-1:0] : w_trial[PERIOD_W-1:0];
    assign n_q     = {r_q[QUOT_W-2:0], w_ge};

    // Sequence one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift the quotient in as the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;

endmodule

/* rtl/core/line_follow_pid_differential_drive.sv */
// Channel  Dir  Word fields                          Handshake
// i_in     in   position[12:0]                       i_in.valid / i_in.ready
// o_out    out  left_speed, right_speed, command     o_out.valid / o_out.ready
//
// Each word is taken in the idle state, then runs through one load state, four passes
// through the shared 20-step shift-add multiplier and one output state before the idle
// state takes the next word.
// The 13-step restoring divider for the derivative runs beside the first multiply pass.
// Reset is synchronous and active low; it restores the register defaults and clears the
// integral, the error history and the last command.
// A result waits in the output register while the next word is accepted and worked on;
// only the output cycle stalls until that register is free.
`include "line_follow_pid_differential_drive_defines.svh"

module line_follow_pid_differential_drive (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lfpd_in_if.sink                         i_in,
    lfpd_out_if.source                      o_out
);
    import lfpd_pkg::*;

    localparam int               IPROD_W = LIMIT_W + PERIOD_W;
    localparam int               TERM_W  = GAIN_W + POS_W - FRAC_W;
    localparam int               DRV_W   = CMD_W + 2;
    localparam logic [CMD_W-1:0] CMD_MAX = {1'b0, {(CMD_W-1){1'b1}}};
    localparam logic [CMD_W-1:0] CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOAD   = 7'b0000010,
        S_MUL_I  = 7'b0000100,
        S_MUL_P  = 7'b0001000,
        S_MUL_IG = 7'b0010000,
        S_MUL_D  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    // Clamp a signed drive value to 0..max
    function automatic logic [SPEED_W-1:0] f_drive(input logic [DRV_W-1:0] v,
                                                   input logic [SPEED_W-1:0] max);
        logic [SPEED_W-1:0] res;
        if (v[DRV_W-1]) begin
            res = '0;
        end else if (v > DRV_W'(max)) begin
            res = max;
        end else begin
            res = v[SPEED_W-1:0];
        end
        return res;
    endfunction

    t_state r_state, n_state;

    logic [SETP_W-1:0]   r_setpoint;
    logic [GAIN_W-1:0]   r_prop_gain;
    logic [GAIN_W-1:0]   r_integ_gain;
    logic [GAIN_W-1:0]   r_deriv_gain;
    logic [PERIOD_W-1:0] r_loop_period;
    logic [SPEED_W-1:0]  r_base_speed;
    logic [SPEED_W-1:0]  r_max_speed;
    logic [LIMIT_W-1:0]  r_integ_limit;

    logic [INTEG_W-1:0]  r_integral;
    logic [ERR_W-1:0]    r_err_prev;
    logic [ERR_W-1:0]    r_err_prev2;
    logic [CMD_W-1:0]    r_last_cmd;

    logic [ERR_W-1:0]    r_err;
    logic                r_integ_en;
    logic                r_dneg;
    logic [QUOT_W-1:0]   r_quot;
    logic [SUM_W-1:0]    r_sum;

    logic                r_out_valid;
    logic [SPEED_W-1:0]  r_left;
    logic [SPEED_W-1:0]  r_right;
    logic [CMD_W-1:0]    r_cmd;

    logic                w_in_acc;
    logic                w_out_free;
    logic [ERR_W-1:0]    n_err;
    logic                w_err_neg;
    logic [ERR_W-1:0]    w_err_negv;
    logic [POS_W-1:0]    w_err_mag;
    logic [LIMIT_W-1:0]  w_integrand;
    logic [ERR_W:0]      w_diff;
    logic [ERR_W:0]      w_diff_negv;
    logic [ERR_W:0]      w_diff_mag;
    logic [QUOT_W-1:0]   w_dhalf;
    logic                w_integ_en;
    logic [INTEG_W:0]    w_isum;
    logic [INTEG_W-1:0]  n_integral;
    logic [SUM_W-1:0]    w_pd_mag;
    logic [SUM_W-1:0]    w_pd_negv;
    logic [SUM_W-1:0]    w_i_term;
    logic                w_sat_hi;
    logic                w_sat_lo;
    logic [CMD_W-1:0]    w_cmd;
    logic [DRV_W-1:0]    w_left;
    logic [DRV_W-1:0]    w_right;

    logic                w_mul_start;
    logic [MUL_A_W-1:0]  w_mul_a;
    logic [MUL_B_W-1:0]  w_mul_b;
    logic [MUL_P_W-1:0]  w_prod;
    t_unit_sts           w_mul_sts;
    logic                w_div_start;
    logic [QUOT_W-1:0]   w_div_quot;
    t_unit_sts           w_div_sts;

    // Handshakes
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Error and its pieces
    assign n_err       = {1'b0, r_setpoint} - {1'b0, i_in.position};
    assign w_err_neg   = r_err[ERR_W-1];
    assign w_err_negv  = -r_err;
    assign w_err_mag   = w_err_neg ? w_err_negv[POS_W-1:0] : r_err[POS_W-1:0];
    assign w_integrand = w_err_neg ? '0 :
                         ((r_err[LIMIT_W-1:0] > r_integ_limit) ? r_integ_limit
                                                               : r_err[LIMIT_W-1:0]);

    // Halved magnitude of the two-sample error difference
    assign w_diff      = {r_err[ERR_W-1], r_err} - {r_err_prev2[ERR_W-1], r_err_prev2};
    assign w_diff_negv = -w_diff;
    assign w_diff_mag  = w_diff[ERR_W] ? w_diff_negv : w_diff;
    assign w_dhalf     = w_diff_mag[QUOT_W:1];

    // Integrate only while the last command sits strictly inside 0..max
    assign w_integ_en = !r_last_cmd[CMD_W-1] && (r_last_cmd != '0)
                        && (r_last_cmd[CMD_W-2:0] < (CMD_W-1)'(r_max_speed));

    // Saturating integral update
    assign w_isum     = {1'b0, r_integral} + (INTEG_W+1)'(w_prod[IPROD_W-1:0]);
    assign n_integral = w_isum[INTEG_W] ? {INTEG_W{1'b1}} : w_isum[INTEG_W-1:0];

    // Scaled P, I and D terms
    assign w_pd_mag  = SUM_W'(w_prod[FRAC_W+TERM_W-1:FRAC_W]);
    assign w_pd_negv = -w_pd_mag;
    assign w_i_term  = SUM_W'(w_prod[MUL_P_W-1:FRAC_W]);

    // Command saturation and wheel drives
    assign w_sat_hi = !r_sum[SUM_W-1] && (|r_sum[SUM_W-2:CMD_W-1]);
    assign w_sat_lo = r_sum[SUM_W-1] && !(&r_sum[SUM_W-2:CMD_W-1]);
    assign w_cmd    = w_sat_hi ? CMD_MAX : (w_sat_lo ? CMD_MIN : r_sum[CMD_W-1:0]);
    assign w_left   = DRV_W'(r_base_speed) + {{(DRV_W-CMD_W){w_cmd[CMD_W-1]}}, w_cmd};
    assign w_right  = DRV_W'(r_base_speed) - {{(DRV_W-CMD_W){w_cmd[CMD_W-1]}}, w_cmd};

    // Feed the shared multiplier pass by pass
    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = MUL_A_W'(w_integrand);
        w_mul_b     = MUL_B_W'(r_loop_period);
        case (r_state)
            S_LOAD: begin
                w_mul_start = 1'b1;
            end
            S_MUL_I: begin
                w_mul_start = w_mul_sts.done;
                w_mul_a     = MUL_A_W'(w_err_mag);
                w_mul_b     = r_prop_gain;
            end
            S_MUL_P: begin
                w_mul_start = w_mul_sts.done;
                w_mul_a     = r_integral;
                w_mul_b     = r_integ_gain;
            end
            S_MUL_IG: begin
                w_mul_start = w_mul_sts.done;
                w_mul_a     = (r_loop_period == '0) ? '0 : MUL_A_W'(r_quot);
                w_mul_b     = r_deriv_gain;
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    assign w_div_start = (r_state == S_LOAD);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_LOAD;
            S_LOAD:   n_state = S_MUL_I;
            S_MUL_I:  if (w_mul_sts.done) n_state = S_MUL_P;
            S_MUL_P:  if (w_mul_sts.done) n_state = S_MUL_IG;
            S_MUL_IG: if (w_mul_sts.done) n_state = S_MUL_D;
            S_MUL_D:  if (w_mul_sts.done) n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and loop history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_setpoint    <= SETPOINT_RST;
            r_prop_gain   <= PROP_GAIN_RST;
            r_integ_gain  <= INTEG_GAIN_RST;
            r_deriv_gain  <= DERIV_GAIN_RST;
            r_loop_period <= LOOP_PERIOD_RST;
            r_base_speed  <= BASE_SPEED_RST;
            r_max_speed   <= MAX_SPEED_RST;
            r_integ_limit <= INTEG_LIMIT_RST;
            r_integral    <= '0;
            r_err_prev    <= '0;
            r_err_prev2   <= '0;
            r_last_cmd    <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_SETPOINT:    r_setpoint    <= i_cfg_data[SETP_W-1:0];
                    REG_PROP_GAIN:   r_prop_gain   <= i_cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                    REG_LOOP_PERIOD: r_loop_period <= i_cfg_data[PERIOD_W-1:0];
                    REG_BASE_SPEED:  r_base_speed  <= i_cfg_data[SPEED_W-1:0];
                    REG_MAX_SPEED:   r_max_speed   <= i_cfg_data[SPEED_W-1:0];
                    REG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if ((r_state == S_MUL_I) && w_mul_sts.done && r_integ_en) begin
                r_integral <= n_integral;
            end

            // Hold the result until taken; drop valid once it leaves
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
                r_last_cmd  <= w_cmd;
                r_err_prev2 <= r_err_prev;
                r_err_prev  <= r_err;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and output word
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err <= n_err;
        end
        if (r_state == S_LOAD) begin
            r_integ_en <= w_integ_en;
            r_dneg     <= w_diff[ERR_W];
        end
        if (w_div_sts.done) begin
            r_quot <= w_div_quot;
        end
        if (w_mul_sts.done) begin
            case (r_state)
                S_MUL_P:  r_sum <= w_err_neg ? w_pd_negv : w_pd_mag;
                S_MUL_IG: r_sum <= r_sum + w_i_term;
                S_MUL_D:  r_sum <= r_sum + (r_dneg ? w_pd_negv : w_pd_mag);
                default:  r_sum <= r_sum;
            endcase
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_cmd   <= w_cmd;
            r_left  <= f_drive(w_left, r_max_speed);
            r_right <= f_drive(w_right, r_max_speed);
        end
    end

    lfpd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_sts   (w_mul_sts),
        .o_prod  (w_prod)
    );

    lfpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dhalf),
        .i_divisor  (r_loop_period),
        .o_sts      (w_div_sts),
        .o_quot     (w_div_quot)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.left_speed  = r_left;
    assign o_out.right_speed = r_right;
    assign o_out.command     = r_cmd;

    `LFPD_ASSERT_IMPL(a_div_first, i_clk, i_rst_n, (r_state == S_MUL_I) && w_mul_sts.done, !w_div_sts.busy, "derivative quotient not ready in time")
    `LFPD_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && w_out_free, r_out_valid && (r_state == S_IDLE), "result word not loaded")
    `LFPD_ASSERT_IMPL(a_out_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_OUT), "result word appeared outside output step")

endmodule

/* tb/lfpd_checker.sv */
module lfpd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [lfpd_pkg::POS_W-1:0]      i_position,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [lfpd_pkg::SPEED_W-1:0]    i_left_speed,
    input  logic [lfpd_pkg::SPEED_W-1:0]    i_right_speed,
    input  logic [lfpd_pkg::CMD_W-1:0]      i_command,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lfpd_pkg::*;

    localparam longint ACC_MAX = 64'sh7FFF_FFFF;

    typedef struct packed {
        logic [SPEED_W-1:0] left_speed;
        logic [SPEED_W-1:0] right_speed;
        logic [CMD_W-1:0]   command;
    } t_drive_word;

    // Shadow copy of the tuning registers
    logic [SETP_W-1:0]   setpoint_r;
    logic [GAIN_W-1:0]   kp_r;
    logic [GAIN_W-1:0]   ki_r;
    logic [GAIN_W-1:0]   kd_r;
    logic [PERIOD_W-1:0] period_r;
    logic [SPEED_W-1:0]  base_r;
    logic [SPEED_W-1:0]  top_r;
    logic [LIMIT_W-1:0]  limit_r;

    // Loop state mirrored from the controller
    logic signed [31:0]      integ_acc;
    logic signed [ERR_W-1:0] err_d1;
    logic signed [ERR_W-1:0] err_d2;
    logic signed [CMD_W-1:0] cmd_last;

    t_drive_word drive_q[$];
    int          fail_count = 0;

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the loop state by one position sample and form the drive word
    function automatic t_drive_word predict_drive(input logic [POS_W-1:0] pos);
        longint      err;
        longint      integrand;
        longint      rate;
        longint      p_term;
        longint      i_term;
        longint      d_term;
        longint      cmd;
        t_drive_word w;
        err = longint'(setpoint_r) - longint'(pos);
        integrand = clamp_to(err, 0, longint'(limit_r));
        // integrate only while the last command sits inside the drive window
        if (cmd_last > 0 && longint'(cmd_last) < longint'(top_r)) begin
            integ_acc = 32'(clamp_to(longint'(integ_acc) + integrand * longint'(period_r),
                                     0, ACC_MAX));
        end
        rate = 0;
        if (period_r != '0) begin
            rate = ((err - longint'(err_d2)) / 2) / longint'(period_r);
        end
        p_term = (longint'(kp_r) * err) / 65536;
        i_term = (longint'(ki_r) * longint'(integ_acc)) / 65536;
        d_term = (longint'(kd_r) * rate) / 65536;
        err_d2 = err_d1;
        err_d1 = ERR_W'(err);
        cmd = clamp_to(p_term + i_term + d_term, -32768, 32767);
        cmd_last = CMD_W'(cmd);
        w.left_speed  = SPEED_W'(clamp_to(longint'(base_r) + cmd, 0, longint'(top_r)));
        w.right_speed = SPEED_W'(clamp_to(longint'(base_r) - cmd, 0, longint'(top_r)));
        w.command     = CMD_W'(cmd);
        return w;
    endfunction

    // Track register writes, predict each accepted sample, compare each drive word
    always @(posedge i_clk) begin
        t_drive_word want;
        if (!i_rst_n) begin
            setpoint_r = SETPOINT_RST;
            kp_r       = PROP_GAIN_RST;
            ki_r       = INTEG_GAIN_RST;
            kd_r       = DERIV_GAIN_RST;
            period_r   = LOOP_PERIOD_RST;
            base_r     = BASE_SPEED_RST;
            top_r      = MAX_SPEED_RST;
            limit_r    = INTEG_LIMIT_RST;
            integ_acc  = '0;
            err_d1     = '0;
            err_d2     = '0;
            cmd_last   = '0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_SETPOINT:    setpoint_r = i_cfg_data[SETP_W-1:0];
                    REG_PROP_GAIN:   kp_r       = i_cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:  ki_r       = i_cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:  kd_r       = i_cfg_data[GAIN_W-1:0];
                    REG_LOOP_PERIOD: period_r   = i_cfg_data[PERIOD_W-1:0];
                    REG_BASE_SPEED:  base_r     = i_cfg_data[SPEED_W-1:0];
                    REG_MAX_SPEED:   top_r      = i_cfg_data[SPEED_W-1:0];
                    REG_INTEG_LIMIT: limit_r    = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (drive_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected drive word: left %0d right %0d command %0d",
                                 i_left_speed, i_right_speed, $signed(i_command));
                    end
                    fail_count++;
                end else begin
                    want = drive_q.pop_front();
                    if (want.left_speed !== i_left_speed || want.right_speed !== i_right_speed
                        || want.command !== i_command) begin
                        if (fail_count < 10) begin
                            $display("drive word mismatch: expected left %0d right %0d cmd %0d, %s",
                                     want.left_speed, want.right_speed, $signed(want.command),
                                     $sformatf("got left %0d right %0d cmd %0d", i_left_speed,
                                               i_right_speed, $signed(i_command)));
                        end
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                drive_q.push_back(predict_drive(i_position));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= drive_q.size();
    end

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lfpd_pkg::*;

    typedef enum {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_HOLD} t_rx_mode;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    int                    burst_left = 0;
    logic [SETP_W-1:0]     cur_setpoint = SETPOINT_RST;

    t_rx_mode              rx_mode = RX_OPEN;
    int                    rx_left = 0;
    int                    rx_hold = 0;
    int                    rx_tick = 0;

    lfpd_in_if  pos_ch ();
    lfpd_out_if drive_ch ();

    line_follow_pid_differential_drive i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (pos_ch),
        .o_out      (drive_ch)
    );

    lfpd_checker drive_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (pos_ch.valid),
        .i_in_ready    (pos_ch.ready),
        .i_position    (pos_ch.position),
        .i_out_valid   (drive_ch.valid),
        .i_out_ready   (drive_ch.ready),
        .i_left_speed  (drive_ch.left_speed),
        .i_right_speed (drive_ch.right_speed),
        .i_command     (drive_ch.command),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the drive side on a pattern that switches mode every so often
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:        drive_ch.ready <= 1'b1;
            RX_COIN:        drive_ch.ready <= 1'($urandom_range(0, 1));
            RX_EVERY_THIRD: drive_ch.ready <= (rx_tick % 3 == 0);
            default: begin
                // long stalls broken by single open cycles
                if (rx_hold == 0) begin
                    rx_hold = $urandom_range(0, 60);
                    drive_ch.ready <= 1'b1;
                end else begin
                    rx_hold--;
                    drive_ch.ready <= 1'b0;
                end
            end
        endcase
    end

    // Offer one position word, opening a new burst after a random gap when due
    task automatic send_position(input logic [POS_W-1:0] pos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 6);
            if (gap != 0) begin
                pos_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        pos_ch.valid    <= 1'b1;
        pos_ch.position <= pos;
        @(posedge clk);
        while (!pos_ch.ready) @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    // Drop valid and hold until every drive word has come back
    task automatic wait_drained();
        pos_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_tuning_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    // Write all eight registers, with junk above the width of each register narrower than the bus
    task automatic load_tuning(input logic [SETP_W-1:0] sp, input logic [GAIN_W-1:0] kp,
                               input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd,
                               input logic [PERIOD_W-1:0] per, input logic [SPEED_W-1:0] base,
                               input logic [SPEED_W-1:0] top, input logic [LIMIT_W-1:0] lim);
        write_tuning_reg(REG_SETPOINT,    {7'($urandom), sp});
        write_tuning_reg(REG_PROP_GAIN,   kp);
        write_tuning_reg(REG_INTEG_GAIN,  ki);
        write_tuning_reg(REG_DERIV_GAIN,  kd);
        write_tuning_reg(REG_LOOP_PERIOD, {4'($urandom), per});
        write_tuning_reg(REG_BASE_SPEED,  {12'($urandom), base});
        write_tuning_reg(REG_MAX_SPEED,   {12'($urandom), top});
        write_tuning_reg(REG_INTEG_LIMIT, {7'($urandom), lim});
        cfg_we <= 1'b0;
        cur_setpoint = sp;
    endtask

    initial begin
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [GAIN_W-1:0]   kd;
        logic [PERIOD_W-1:0] per;
        logic [SPEED_W-1:0]  base;
        logic [SPEED_W-1:0]  top;
        logic [SETP_W-1:0]   sp;
        logic [LIMIT_W-1:0]  lim;
        logic [POS_W-1:0]    pos;
        int                  walk;
        int                  pick;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= REG_SETPOINT;
        cfg_data        <= '0;
        pos_ch.valid    <= 1'b0;
        pos_ch.position <= '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset tuning: both position extremes, centered line, small offsets
        send_position(13'd0);
        send_position(13'h1FFF);
        send_position(13'd3500);
        send_position(13'd3500);
        send_position(13'd3499);
        send_position(13'd3501);
        send_position(13'd4096);

        // Zero loop period with full gains: bypassed divider, saturated command
        wait_drained();
        load_tuning(13'h1FFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'd0, 8'd255, 8'd255, 13'h1FFF);
        send_position(13'd0);
        send_position(13'h1FFF);
        send_position(13'd0);
        send_position(13'h1FFF);

        // Everything zero but a loop period of one: empty drive window
        wait_drained();
        load_tuning(13'd0, 20'd0, 20'd0, 20'd0, 16'd1, 8'd0, 8'd0, 13'd0);
        send_position(13'd0);
        send_position(13'h1FFF);

        // Negative saturation with base above max
        wait_drained();
        load_tuning(13'd0, 20'hFFFFF, 20'd0, 20'hFFFFF, 16'hFFFF, 8'd128, 8'd100, 13'h1FFF);
        send_position(13'h1FFF);
        send_position(13'd1);

        // Random tuning phases, samples mostly follow a wandering line
        walk = 3500;
        for (int ph = 0; ph < 10; ph++) begin
            wait_drained();
            kp = 20'($urandom) >> $urandom_range(2, 19);
            ki = ($urandom_range(0, 1) == 0) ? '0 : 20'($urandom) >> $urandom_range(8, 19);
            kd = 20'($urandom) >> $urandom_range(2, 19);
            case ($urandom_range(0, 7))
                0:       per = '0;
                1:       per = '1;
                default: per = 16'($urandom_range(1, 2000));
            endcase
            sp   = 13'($urandom);
            base = 8'($urandom);
            top  = 8'($urandom);
            lim  = 13'($urandom);
            load_tuning(sp, kp, ki, kd, per, base, top, lim);
            walk = cur_setpoint;
            for (int n = 0; n < 95; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    walk += int'($urandom_range(0, 600)) - 300;
                    if (walk < 0) walk = 0;
                    if (walk > 8191) walk = 8191;
                    pos = 13'(walk);
                end else if (pick < 80) begin
                    walk = cur_setpoint;
                    pos = cur_setpoint;
                end else if (pick < 95) begin
                    pos = 13'($urandom);
                end else begin
                    pos = ($urandom_range(0, 1) == 0) ? '0 : '1;
                end
                if ($urandom_range(0, 59) == 0) wait_drained();
                send_position(pos);
            end
        end

        // Integral windup to saturation under a small steady command
        wait_drained();
        load_tuning(13'h1FFF, 20'd16, 20'd0, 20'd0, 16'hFFFF, 8'd100, 8'd255, 13'h1FFF);
        repeat (7) send_position(13'd0);

        // Saturated integral through full integral gain, base above max
        wait_drained();
        load_tuning(13'h1FFF, 20'd0, 20'hFFFFF, 20'd0, 16'd250, 8'd200, 8'd10, 13'h1FFF);
        send_position(13'd0);
        send_position(13'h1FFF);

        // Settle, then watch for stray words for about one word time
        wait_drained();
        repeat (100) @(negedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Give up well past the slowest legal run
    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
